### rtl/core/script_line_tokenizer_macros.svh
// Assertion macros used by the tokenizer checker.
`ifndef SCRIPT_LINE_TOKENIZER_MACROS_SVH
`define SCRIPT_LINE_TOKENIZER_MACROS_SVH

// Clocked assertion with reset disable and a generic message.
`define SLT_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: check failed");

// Clocked assertion with reset disable and a caller message.
`define SLT_ASSERT_MSG(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

`endif

### rtl/core/slt_pkg.sv
// Types, codes and character classes of the script line tokenizer.
package slt_pkg;

	typedef enum logic [1:0] {
		EV_BYTE      = 2'd0,
		EV_TOKEN_END = 2'd1,
		EV_STMT_END  = 2'd2
	} ev_t;

	typedef enum logic [2:0] {
		TT_NUMBER = 3'd0,
		TT_WORD   = 3'd1,
		TT_LABEL  = 3'd2,
		TT_DELIM  = 3'd3,
		TT_MINUS  = 3'd4
	} tok_t;

	typedef enum logic [1:0] {
		MD_IDLE  = 2'd0,
		MD_TOKEN = 2'd1,
		MD_QUOTE = 2'd2,
		MD_DONE  = 2'd3
	} mode_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_QUOTE = 8'h22;

	typedef struct packed {
		ev_t        event_res;
		tok_t       token_type;
		logic [7:0] token_index;
		logic [7:0] text_byte;
		logic       last;
	} result_t;

	typedef struct packed {
		mode_t      mode;
		tok_t       cur_type;
		logic       label_word_seen;
		logic [7:0] token_count;
	} lex_state_t;

	// Results of one byte, handed from the lexer to the result queue.
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'd48 && c <= 8'd57;
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122) || c == CH_UNDER;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
	endfunction

	function automatic logic is_other(input logic [7:0] c);
		return c != CH_NUL && !is_digit(c) && !is_letter(c) && !is_space(c) &&
			c != CH_QUOTE && c != CH_MINUS;
	endfunction

endpackage

### rtl/core/slt_lexer.sv
// Combinational lexer step: one byte and the lexer state give results and next state.
module slt_lexer #(
	parameter int MAX_TOKENS = 255
) (
	input  logic [7:0]          ch,
	input  slt_pkg::lex_state_t st,
	output slt_pkg::lex_state_t nxt,
	output slt_pkg::push_t      res
);

	localparam int CapInt = (MAX_TOKENS < 255) ? MAX_TOKENS : 255;
	localparam logic [7:0] Cap = 8'(CapInt);

	typedef struct packed {
		logic                emit;
		slt_pkg::result_t    res;
		slt_pkg::lex_state_t st;
	} start_t;

	function automatic slt_pkg::result_t mk(input slt_pkg::ev_t ev, input slt_pkg::tok_t ty,
		input logic [7:0] idx, input logic [7:0] b);
		slt_pkg::result_t r;
		r.event_res   = ev;
		r.token_type  = ty;
		r.token_index = idx;
		r.text_byte   = b;
		r.last        = 1'b0;
		return r;
	endfunction

	function automatic logic [7:0] bump(input logic [7:0] cnt);
		return (cnt < Cap) ? cnt + 8'd1 : cnt;
	endfunction

	// Handles a byte that arrives between tokens.
	function automatic start_t start_tok(input logic [7:0] c, input slt_pkg::lex_state_t s);
		start_t o;
		o.emit = 1'b0;
		o.res  = '0;
		o.st   = s;
		if (c == slt_pkg::CH_NUL) begin
			o.emit = 1'b1;
			o.res  = mk(slt_pkg::EV_STMT_END, slt_pkg::TT_NUMBER, s.token_count, 8'd0);
			o.st.mode = slt_pkg::MD_IDLE;
			o.st.token_count = 8'd0;
		end else if (slt_pkg::is_space(c)) begin
			o.emit = 1'b0;
		end else if (c == slt_pkg::CH_SEMI) begin
			o.emit = 1'b1;
			o.res  = mk(slt_pkg::EV_STMT_END, slt_pkg::TT_NUMBER, s.token_count, 8'd0);
			o.st.mode = slt_pkg::MD_DONE;
		end else if (c == slt_pkg::CH_QUOTE) begin
			o.st.mode = slt_pkg::MD_QUOTE;
			o.st.cur_type = slt_pkg::TT_WORD;
		end else begin
			priority if (c == slt_pkg::CH_MINUS) begin
				o.st.cur_type = slt_pkg::TT_MINUS;
			end else if (c == slt_pkg::CH_STAR && s.token_count == 8'd0) begin
				o.st.cur_type = slt_pkg::TT_LABEL;
			end else if (slt_pkg::is_digit(c)) begin
				o.st.cur_type = slt_pkg::TT_NUMBER;
			end else if (slt_pkg::is_letter(c)) begin
				o.st.cur_type = slt_pkg::TT_WORD;
			end else begin
				o.st.cur_type = slt_pkg::TT_DELIM;
			end
			o.st.label_word_seen = 1'b0;
			o.st.mode = slt_pkg::MD_TOKEN;
			o.emit = 1'b1;
			o.res  = mk(slt_pkg::EV_BYTE, o.st.cur_type, s.token_count, c);
		end
		return o;
	endfunction

	logic                ext;
	slt_pkg::tok_t       ext_type;
	logic                ext_lws;
	slt_pkg::lex_state_t closed;
	start_t              so;

	// Does the byte extend the open token, and how does it change the type?
	always_comb begin
		ext      = 1'b0;
		ext_type = st.cur_type;
		ext_lws  = st.label_word_seen;
		if (ch != slt_pkg::CH_NUL) begin
			unique case (st.cur_type)
				slt_pkg::TT_NUMBER: begin
					if (slt_pkg::is_letter(ch)) begin
						ext = 1'b1;
						ext_type = slt_pkg::TT_WORD;
					end else begin
						ext = slt_pkg::is_digit(ch);
					end
				end
				slt_pkg::TT_WORD: ext = slt_pkg::is_letter(ch) || slt_pkg::is_digit(ch);
				slt_pkg::TT_LABEL: begin
					if (!st.label_word_seen && ch == slt_pkg::CH_STAR) begin
						ext = 1'b1;
					end else if (slt_pkg::is_letter(ch)) begin
						ext = 1'b1;
						ext_lws = 1'b1;
					end else begin
						ext = slt_pkg::is_digit(ch);
					end
				end
				slt_pkg::TT_DELIM: ext = slt_pkg::is_other(ch);
				default: ext = (ch == slt_pkg::CH_MINUS);
			endcase
		end
	end

	always_comb begin
		closed = st;
		closed.mode = slt_pkg::MD_IDLE;
		closed.token_count = bump(st.token_count);
		so = start_tok(ch, (st.mode == slt_pkg::MD_IDLE) ? st : closed);
	end

	always_comb begin
		nxt    = st;
		res.n  = 2'd0;
		res.r0 = '0;
		res.r1 = '0;
		unique case (st.mode)
			slt_pkg::MD_IDLE: begin
				nxt = so.st;
				if (so.emit) begin
					res.n  = 2'd1;
					res.r0 = so.res;
				end
			end
			slt_pkg::MD_TOKEN: begin
				if (ext) begin
					nxt.cur_type = ext_type;
					nxt.label_word_seen = ext_lws;
					res.n  = 2'd1;
					res.r0 = mk(slt_pkg::EV_BYTE, ext_type, st.token_count, ch);
				end else begin
					// The byte closes the token and is then taken as a fresh start.
					res.r0 = mk(slt_pkg::EV_TOKEN_END, st.cur_type, st.token_count, 8'd0);
					nxt = so.st;
					if (so.emit) begin
						res.n  = 2'd2;
						res.r1 = so.res;
					end else begin
						res.n  = 2'd1;
					end
				end
			end
			slt_pkg::MD_QUOTE: begin
				if (ch == slt_pkg::CH_NUL || ch == slt_pkg::CH_QUOTE) begin
					res.r0 = mk(slt_pkg::EV_TOKEN_END, st.cur_type, st.token_count, 8'd0);
					nxt = closed;
					res.n = 2'd1;
					if (ch == slt_pkg::CH_NUL) begin
						res.r1 = mk(slt_pkg::EV_STMT_END, slt_pkg::TT_NUMBER,
							closed.token_count, 8'd0);
						nxt.token_count = 8'd0;
						res.n = 2'd2;
					end
				end else begin
					res.n  = 2'd1;
					res.r0 = mk(slt_pkg::EV_BYTE, st.cur_type, st.token_count, ch);
				end
			end
			default: begin
				if (ch == slt_pkg::CH_NUL) begin
					nxt.mode = slt_pkg::MD_IDLE;
					nxt.token_count = 8'd0;
				end
			end
		endcase
		res.r0.last = (res.n == 2'd1);
		res.r1.last = 1'b1;
	end

endmodule

### rtl/core/slt_outbuf.sv
// Two-entry result queue that holds lexer results until the result port takes them.
module slt_outbuf (
	input  logic             clk,
	input  logic             arst_n,
	input  slt_pkg::push_t   push,
	input  logic             pop,
	output logic [1:0]       free,
	output logic             head_valid,
	output slt_pkg::result_t head
);

	slt_pkg::result_t ent0_q, ent1_q, ent0_d, ent1_d;
	logic [1:0]       cnt_q, cnt_d, cnt_pop;

	assign head_valid = (cnt_q != 2'd0);
	assign head       = ent0_q;
	assign free       = 2'd2 - cnt_q + {1'b0, pop};

	always_comb begin
		ent0_d  = pop ? ent1_q : ent0_q;
		ent1_d  = ent1_q;
		cnt_pop = cnt_q - {1'b0, pop};
		cnt_d   = cnt_pop + push.n;
		if (push.n != 2'd0) begin
			if (cnt_pop == 2'd0) begin
				ent0_d = push.r0;
				ent1_d = push.r1;
			end else begin
				ent1_d = push.r0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		ent0_q <= ent0_d;
		ent1_q <= ent1_d;
	end

endmodule

### rtl/core/script_line_tokenizer.sv
// Top level of the script line tokenizer: input register, lexer state and result queue.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------------------------------------------
//  input   | ch_valid  | ch_stall  | ch
//  result  | res_valid | res_stall | event_res, token_type, token_index, text_byte, last
//
// An item waits in the input register, where the lexer step runs, and its results are
// registered in the two-entry result queue when the item is consumed.
// One input item per cycle while each gives at most one result and res_stall is low;
// an item that closes a token and opens another gives two, so a run of them stalls input.
// Reset clears the lexer state to between tokens with a count of zero, and empties the queue.
// An item stays in the input register while the queue lacks room for all of its results.
module script_line_tokenizer #(
	parameter int MAX_TOKENS = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       ch_valid,
	output logic       ch_stall,
	input  logic [7:0] ch,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [1:0] event_res,
	output logic [2:0] token_type,
	output logic [7:0] token_index,
	output logic [7:0] text_byte,
	output logic       last
);

	logic                valid_s1;
	logic [7:0]          ch_s1;
	slt_pkg::lex_state_t state_q, state_d;
	slt_pkg::push_t      step, push;
	slt_pkg::result_t    head;
	logic [1:0]          free;
	logic                consume, pop;

	slt_lexer #(.MAX_TOKENS(MAX_TOKENS)) u_lexer (
		.ch  (ch_s1),
		.st  (state_q),
		.nxt (state_d),
		.res (step)
	);

	assign pop     = res_valid && !res_stall;
	assign consume = valid_s1 && (step.n <= free);
	assign ch_stall = valid_s1 && !consume;

	always_comb begin
		push = step;
		if (!consume) begin
			push.n = 2'd0;
		end
	end

	slt_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (pop),
		.free       (free),
		.head_valid (res_valid),
		.head       (head)
	);

	assign event_res   = head.event_res;
	assign token_type  = head.token_type;
	assign token_index = head.token_index;
	assign text_byte   = head.text_byte;
	assign last        = head.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= '{mode: slt_pkg::MD_IDLE, cur_type: slt_pkg::TT_NUMBER,
				label_word_seen: 1'b0, token_count: 8'd0};
		end else begin
			if (!ch_stall) begin
				valid_s1 <= ch_valid;
			end
			if (consume) begin
				state_q <= state_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ch_valid && !ch_stall) begin
			ch_s1 <= ch;
		end
	end

endmodule

### rtl/core/slt_checker.sv
// Port-level checks of the script line tokenizer and their binding to the top level.
`include "script_line_tokenizer_macros.svh"

module slt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       ch_valid,
	input logic       ch_stall,
	input logic [7:0] ch,
	input logic       res_valid,
	input logic       res_stall,
	input logic [1:0] event_res,
	input logic [2:0] token_type,
	input logic [7:0] token_index,
	input logic [7:0] text_byte,
	input logic       last
);

	`SLT_ASSERT(a_res_hold, clk, arst_n, res_valid && res_stall |=> res_valid && $stable(event_res) && $stable(token_index) && $stable(text_byte) && $stable(last))

	`SLT_ASSERT_MSG(a_stmt_end_shape, clk, arst_n, res_valid && event_res == slt_pkg::EV_STMT_END |-> token_type == slt_pkg::TT_NUMBER && text_byte == 8'd0 && last, "statement end item malformed")

	`SLT_ASSERT_MSG(a_no_text_off_byte, clk, arst_n, res_valid && event_res != slt_pkg::EV_BYTE |-> text_byte == 8'd0, "text byte set outside a token byte item")

	// With the result queue empty there is room for any item, so input never stalls.
	`SLT_ASSERT(a_empty_no_stall, clk, arst_n, !res_valid |-> !ch_stall)

endmodule

bind script_line_tokenizer slt_checker u_slt_checker (.*);

### tb/tb_script_line_tokenizer.sv
// Self-checking testbench for the script line tokenizer: directed and random byte streams.
module tb_script_line_tokenizer;
	timeunit 1ns;
	timeprecision 1ps;

	import slt_pkg::*;

	localparam int MAX_TOKENS   = 255;
	localparam int TOKEN_CAP    = (MAX_TOKENS < 255) ? MAX_TOKENS : 255;
	localparam int QUIET_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 210;
	localparam int DENSE_BYTES  = 264;

	typedef enum {CC_NUL, CC_DIGIT, CC_LETTER, CC_SPACE, CC_QUOTE, CC_MINUS, CC_OTHER} cclass_t;
	typedef enum {GT_NUMBER, GT_WORD, GT_LABEL, GT_DELIM, GT_MINUS, GT_STRING} gen_tok_t;
	typedef enum {SK_SPACED, SK_PACKED, SK_NOISE} stmt_kind_t;
	typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_BLOCKS} rx_mode_t;

	typedef struct {
		logic [7:0] c;
		bit         typed;
		result_t    want;
	} dir_row_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       ch_valid  = 1'b0;
	logic       ch_stall;
	logic [7:0] ch        = 8'h00;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [1:0] event_res;
	logic [2:0] token_type;
	logic [7:0] token_index;
	logic [7:0] text_byte;
	logic       last;

	// Typed expectation that travels with the item currently offered.
	bit      drv_typed = 1'b0;
	result_t drv_want  = '0;

	// Lexer state as the testbench sees it.
	mode_t      lx_mode  = MD_IDLE;
	tok_t       lx_type  = TT_NUMBER;
	bit         lx_alpha = 1'b0;
	logic [7:0] lx_count = 8'd0;

	result_t    step_q[$];
	result_t    exp_q[$];
	result_t    head;
	logic [7:0] stmt_q[$];
	dir_row_t   dir_tab [26];

	int       errors     = 0;
	int       counted    = 0;
	int       quiet      = 0;
	int       burst_left = 0;
	bit       live;
	rx_mode_t rx_mode    = RX_FREE;
	int       rx_left    = 0;

	always #10 clk = ~clk;

	script_line_tokenizer #(.MAX_TOKENS(MAX_TOKENS)) dut (.*);

	function automatic cclass_t classify(logic [7:0] c);
		if (c == CH_NUL)
			return CC_NUL;
		if (c >= 8'h30 && c <= 8'h39)
			return CC_DIGIT;
		if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == CH_UNDER)
			return CC_LETTER;
		if ((c >= 8'h09 && c <= 8'h0D) || c == 8'h20)
			return CC_SPACE;
		if (c == CH_QUOTE)
			return CC_QUOTE;
		if (c == CH_MINUS)
			return CC_MINUS;
		return CC_OTHER;
	endfunction

	function automatic void put_res(ev_t ev, tok_t ty, logic [7:0] idx, logic [7:0] b);
		result_t r;
		r.event_res   = ev;
		r.token_type  = ty;
		r.token_index = idx;
		r.text_byte   = b;
		r.last        = 1'b0;
		step_q = {step_q, r};
	endfunction

	function automatic void add_byte(logic [7:0] c);
		stmt_q = {stmt_q, c};
	endfunction

	// True when c continues the open token; may turn a number into a word.
	function automatic bit grows(logic [7:0] c);
		cclass_t k;
		k = classify(c);
		case (lx_type)
			TT_NUMBER: begin
				if (k == CC_LETTER)
					lx_type = TT_WORD;
				return k == CC_DIGIT || k == CC_LETTER;
			end
			TT_WORD: return k == CC_DIGIT || k == CC_LETTER;
			TT_LABEL: begin
				// Stars only match until the label has taken a letter.
				if (c == CH_STAR)
					return !lx_alpha;
				if (k == CC_LETTER)
					lx_alpha = 1'b1;
				return k == CC_DIGIT || k == CC_LETTER;
			end
			TT_DELIM: return k == CC_OTHER;
			default: return k == CC_MINUS;
		endcase
	endfunction

	function automatic void close_token();
		put_res(EV_TOKEN_END, lx_type, lx_count, 8'h00);
		if (lx_count < TOKEN_CAP)
			lx_count = lx_count + 8'd1;
		lx_mode = MD_IDLE;
	endfunction

	function automatic void open_token(logic [7:0] c);
		cclass_t k;
		k = classify(c);
		if (k == CC_NUL) begin
			put_res(EV_STMT_END, TT_NUMBER, lx_count, 8'h00);
			lx_mode  = MD_IDLE;
			lx_count = 8'd0;
		end else if (c == CH_SEMI) begin
			put_res(EV_STMT_END, TT_NUMBER, lx_count, 8'h00);
			lx_mode = MD_DONE;
		end else if (k == CC_QUOTE) begin
			lx_mode = MD_QUOTE;
			lx_type = TT_WORD;
		end else if (k != CC_SPACE) begin
			case (k)
				CC_MINUS: lx_type = TT_MINUS;
				CC_DIGIT: lx_type = TT_NUMBER;
				CC_LETTER: lx_type = TT_WORD;
				default: lx_type = (c == CH_STAR && lx_count == 8'd0) ? TT_LABEL : TT_DELIM;
			endcase
			lx_alpha = 1'b0;
			lx_mode  = MD_TOKEN;
			put_res(EV_BYTE, lx_type, lx_count, c);
		end
	endfunction

	// Results of one input byte go to step_q.
	function automatic void lex_byte(logic [7:0] c);
		step_q.delete();
		case (lx_mode)
			MD_IDLE: open_token(c);
			MD_TOKEN: begin
				if (grows(c)) begin
					put_res(EV_BYTE, lx_type, lx_count, c);
				end else begin
					close_token();
					open_token(c);
				end
			end
			MD_QUOTE: begin
				if (c == CH_NUL || c == CH_QUOTE) begin
					close_token();
					if (c == CH_NUL)
						open_token(c);
				end else begin
					put_res(EV_BYTE, lx_type, lx_count, c);
				end
			end
			default: begin
				if (c == CH_NUL) begin
					lx_mode  = MD_IDLE;
					lx_count = 8'd0;
				end
			end
		endcase
		if (step_q.size() != 0)
			step_q[step_q.size() - 1].last = 1'b1;
	endfunction

	function automatic logic [7:0] pick(cclass_t k);
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (classify(c) != k);
		return c;
	endfunction

	function automatic logic [7:0] alnum();
		return $urandom_range(0, 1) ? pick(CC_LETTER) : pick(CC_DIGIT);
	endfunction

	function automatic void add_token(gen_tok_t t);
		logic [7:0] c;
		case (t)
			GT_NUMBER: repeat ($urandom_range(1, 4)) add_byte(pick(CC_DIGIT));
			GT_WORD: begin
				add_byte(pick(CC_LETTER));
				repeat ($urandom_range(0, 4)) add_byte(alnum());
			end
			GT_LABEL: begin
				add_byte(CH_STAR);
				repeat ($urandom_range(0, 2)) add_byte(CH_STAR);
				repeat ($urandom_range(0, 4))
					add_byte(($urandom_range(0, 4) == 0) ? CH_STAR : alnum());
			end
			GT_DELIM: repeat ($urandom_range(1, 3)) add_byte(pick(CC_OTHER));
			GT_MINUS: repeat ($urandom_range(1, 3)) add_byte(CH_MINUS);
			default: begin
				add_byte(CH_QUOTE);
				repeat ($urandom_range(0, 4)) begin
					do
						c = 8'($urandom_range(1, 255));
					while (c == CH_QUOTE);
					add_byte(c);
				end
				// Now and then the string stays open and swallows what follows.
				if ($urandom_range(0, 9) != 0)
					add_byte(CH_QUOTE);
			end
		endcase
	endfunction

	function automatic void build_statement();
		stmt_kind_t kind;
		int         r;
		int         ntok;
		stmt_q.delete();
		r    = $urandom_range(0, 9);
		kind = (r < 6) ? SK_SPACED : (r < 8) ? SK_PACKED : SK_NOISE;
		if (kind == SK_NOISE) begin
			repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
		end else begin
			if ($urandom_range(0, 3) == 0)
				add_byte(pick(CC_SPACE));
			ntok = $urandom_range(1, 6);
			for (int i = 0; i < ntok; i++) begin
				add_token((i == 0 && $urandom_range(0, 2) == 0) ? GT_LABEL :
					gen_tok_t'($urandom_range(0, 5)));
				if (kind == SK_SPACED || $urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 2)) add_byte(pick(CC_SPACE));
			end
			if ($urandom_range(0, 3) == 0) begin
				add_byte(CH_SEMI);
				repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(1, 255)));
			end
		end
		add_byte(CH_NUL);
	endfunction

	function automatic dir_row_t dir_typed(logic [7:0] c, ev_t ev, tok_t ty, logic [7:0] idx);
		dir_row_t r;
		r.c                = c;
		r.typed            = 1'b1;
		r.want.event_res   = ev;
		r.want.token_type  = ty;
		r.want.token_index = idx;
		r.want.text_byte   = (ev == EV_BYTE) ? c : 8'h00;
		r.want.last        = 1'b1;
		return r;
	endfunction

	function automatic dir_row_t dir_plain(logic [7:0] c);
		dir_row_t r;
		r.c     = c;
		r.typed = 1'b0;
		r.want  = '0;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	// Offers one item and returns at the edge that accepts it.
	task automatic send_item(input logic [7:0] c, input bit typed, input result_t want);
		if (burst_left == 0) begin
			repeat (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12)) begin
				@(negedge clk);
				ch_valid <= 1'b0;
				ch       <= 8'($urandom_range(0, 255));
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		@(negedge clk);
		ch_valid  <= 1'b1;
		ch        <= c;
		drv_typed <= typed;
		drv_want  <= want;
		do
			@(posedge clk);
		while (ch_stall);
	endtask

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(16, 96);
		end else begin
			rx_left = rx_left - 1;
		end
		case (rx_mode)
			RX_FREE: res_stall <= 1'b0;
			RX_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
			RX_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
			default: res_stall <= rx_left[2];
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (exp_q.size() == 0) begin
					report_mismatch($sformatf("result event %0d index %0d with nothing expected",
						event_res, token_index));
				end else begin
					head = exp_q.pop_front();
					if (event_res !== head.event_res)
						report_mismatch($sformatf("event_res %0d, expected %0d",
							event_res, head.event_res));
					if (token_type !== head.token_type)
						report_mismatch($sformatf("token_type %0d, expected %0d",
							token_type, head.token_type));
					if (token_index !== head.token_index)
						report_mismatch($sformatf("token_index %0d, expected %0d",
							token_index, head.token_index));
					if (text_byte !== head.text_byte)
						report_mismatch($sformatf("text_byte %0h, expected %0h",
							text_byte, head.text_byte));
					if (last !== head.last)
						report_mismatch($sformatf("last %0b, expected %0b", last, head.last));
				end
			end
			if (ch_valid && !ch_stall) begin
				live = (lx_mode != MD_DONE);
				lex_byte(ch);
				if (drv_typed) begin
					exp_q = {exp_q, drv_want};
				end else begin
					foreach (step_q[i])
						exp_q = {exp_q, step_q[i]};
				end
				if (live)
					counted++;
			end
			if ((res_valid && !res_stall) || (ch_valid && !ch_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("FAIL script_line_tokenizer");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [7:0] c;
		int         base;
		dir_tab = '{
			dir_typed(CH_NUL, EV_STMT_END, TT_NUMBER, 8'd0),
			dir_typed(CH_STAR, EV_BYTE, TT_LABEL, 8'd0),
			dir_plain(CH_STAR),
			dir_plain(8'h41),
			dir_plain(CH_STAR),
			dir_plain(8'h39),
			dir_plain(8'h7A),
			dir_plain(8'h20),
			dir_plain(CH_MINUS),
			dir_plain(8'h35),
			dir_plain(8'hFF),
			dir_plain(8'h80),
			dir_plain(CH_QUOTE),
			dir_plain(CH_QUOTE),
			dir_plain(CH_QUOTE),
			dir_plain(8'h71),
			dir_plain(CH_NUL),
			dir_plain(8'h09),
			dir_typed(CH_SEMI, EV_STMT_END, TT_NUMBER, 8'd0),
			dir_plain(8'h78),
			dir_plain(CH_NUL),
			dir_typed(CH_UNDER, EV_BYTE, TT_WORD, 8'd0),
			dir_plain(CH_SEMI),
			dir_plain(CH_NUL),
			dir_plain(8'h37),
			dir_plain(CH_NUL)
		};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i])
			send_item(dir_tab[i].c, dir_tab[i].typed, dir_tab[i].want);

		// Letters and delimiters in turn close a token on every byte, so the count saturates.
		stmt_q.delete();
		for (int i = 0; i < DENSE_BYTES; i++) begin
			if (i % 2 == 0) begin
				add_byte(pick(CC_LETTER));
			end else begin
				do
					c = pick(CC_OTHER);
				while (c == CH_SEMI);
				add_byte(c);
			end
		end
		add_byte(CH_NUL);
		foreach (stmt_q[i])
			send_item(stmt_q[i], 1'b0, '0);

		base = counted;
		while (counted < base + RANDOM_ITEMS) begin
			build_statement();
			foreach (stmt_q[i])
				send_item(stmt_q[i], 1'b0, '0);
		end

		@(negedge clk);
		ch_valid <= 1'b0;
		while (exp_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("PASS script_line_tokenizer");
		else
			$display("FAIL script_line_tokenizer");
		$finish;
	end

endmodule
